/* rtl/core/q2e_pkg.sv */
`timescale 1ns / 1ps
package q2e_pkg;

  localparam int COMPONENT_WIDTH = 16;
  localparam int ANGLE_WIDTH     = 16;
  localparam int WORD_W          = 64;
  localparam int SQRT_STEPS      = 31;
  localparam int ATAN_ENTRIES    = 32;
  localparam int FRAC_BITS       = 2 * (COMPONENT_WIDTH - 2);
  localparam int PROD_SHR        = (FRAC_BITS >= 30) ? FRAC_BITS - 30 : 0;
  localparam int PROD_SHL        = (FRAC_BITS < 30) ? 30 - FRAC_BITS : 0;
  localparam int ANGLE_SH        = 32 - ANGLE_WIDTH;

  typedef logic signed [COMPONENT_WIDTH-1:0]   comp_t;
  typedef logic signed [2*COMPONENT_WIDTH-1:0] prod_t;
  typedef logic signed [ANGLE_WIDTH-1:0]       angle_t;
  typedef logic signed [WORD_W-1:0]            word_t;

  localparam word_t Q30_ONE   = word_t'(64'sd1073741824);
  localparam word_t SQRT_ARG0 = word_t'(64'sd1) <<< 60;

  typedef struct packed {
    comp_t quat_w;
    comp_t quat_x;
    comp_t quat_y;
    comp_t quat_z;
  } in_t;

  typedef struct packed {
    angle_t roll_angle;
    angle_t pitch_angle;
    angle_t yaw_angle;
    logic   pitch_saturated;
  } out_t;

  // sums travelling beside the root extraction
  typedef struct packed {
    word_t sr;
    word_t cr;
    word_t sy;
    word_t cy;
    word_t sp;
    logic  sat;
    logic  sat_neg;
  } side_t;

  typedef struct packed {
    word_t x;
    word_t y;
    word_t z;
    logic  zero;
  } lane_t;

  // atan(2^-i), 2^31 = pi
  localparam logic [31:0] ATAN_TABLE [0:ATAN_ENTRIES-1] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
  };

  function automatic word_t atan_unit(input int idx);
    return word_t'({32'd0, ATAN_TABLE[idx]});
  endfunction

  function automatic word_t prod30(input prod_t p);
    word_t e;
    e = word_t'(p);
    return (e >>> PROD_SHR) <<< PROD_SHL;
  endfunction

  // quadrant fold into the right half plane
  function automatic lane_t cordic_pre(input word_t y, input word_t x);
    lane_t l;
    l.zero = (x == '0) && (y == '0);
    l.x    = x;
    l.y    = y;
    l.z    = '0;
    if (x < 0) begin
      if (y >= 0) begin
        l.x = y;
        l.y = -x;
        l.z = Q30_ONE;
      end else begin
        l.x = -y;
        l.y = x;
        l.z = -Q30_ONE;
      end
    end
    return l;
  endfunction

endpackage

/* rtl/core/q2e_front.sv */
`timescale 1ns / 1ps
module q2e_front (
  input  logic            clk,
  input  logic            en,
  input  q2e_pkg::in_t    in_data,
  output q2e_pkg::side_t  side,
  output q2e_pkg::word_t  root_arg
);

  q2e_pkg::prod_t p_wx, p_yz, p_xx, p_yy, p_wz, p_xy, p_zz, p_wy, p_zx;
  q2e_pkg::side_t sums;
  q2e_pkg::side_t sums_next;
  q2e_pkg::word_t sq;
  logic signed [31:0] sp32;

  // products
  always_ff @(posedge clk) begin
    if (en) begin
      p_wx <= in_data.quat_w * in_data.quat_x;
      p_yz <= in_data.quat_y * in_data.quat_z;
      p_xx <= in_data.quat_x * in_data.quat_x;
      p_yy <= in_data.quat_y * in_data.quat_y;
      p_wz <= in_data.quat_w * in_data.quat_z;
      p_xy <= in_data.quat_x * in_data.quat_y;
      p_zz <= in_data.quat_z * in_data.quat_z;
      p_wy <= in_data.quat_w * in_data.quat_y;
      p_zx <= in_data.quat_z * in_data.quat_x;
    end
  end

  // sums in Q.30
  always_comb begin
    sums_next.sr = (q2e_pkg::prod30(p_wx) + q2e_pkg::prod30(p_yz)) <<< 1;
    sums_next.cr = q2e_pkg::Q30_ONE
                 - ((q2e_pkg::prod30(p_xx) + q2e_pkg::prod30(p_yy)) <<< 1);
    sums_next.sy = (q2e_pkg::prod30(p_wz) + q2e_pkg::prod30(p_xy)) <<< 1;
    sums_next.cy = q2e_pkg::Q30_ONE
                 - ((q2e_pkg::prod30(p_yy) + q2e_pkg::prod30(p_zz)) <<< 1);
    sums_next.sp = (q2e_pkg::prod30(p_wy) - q2e_pkg::prod30(p_zx)) <<< 1;
    sums_next.sat_neg = sums_next.sp <= -q2e_pkg::Q30_ONE;
    sums_next.sat     = (sums_next.sp >= q2e_pkg::Q30_ONE) || sums_next.sat_neg;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sums <= sums_next;
    end
  end

  // pitch sine squared; only meaningful when not saturated
  assign sp32 = sums.sp[31:0];

  always_ff @(posedge clk) begin
    if (en) begin
      sq   <= sp32 * sp32;
      side <= sums;
    end
  end

  assign root_arg = q2e_pkg::SQRT_ARG0 - sq;

endmodule

/* rtl/core/q2e_sqrt_cell.sv */
`timescale 1ns / 1ps
module q2e_sqrt_cell #(
  parameter int STEP = 0
) (
  input  logic           clk,
  input  logic           en,
  input  q2e_pkg::word_t n_in,
  input  q2e_pkg::word_t res_in,
  input  q2e_pkg::side_t side_in,
  output q2e_pkg::word_t n_out,
  output q2e_pkg::word_t res_out,
  output q2e_pkg::side_t side_out
);

  localparam q2e_pkg::word_t BIT =
    q2e_pkg::word_t'(64'sd1) <<< (2 * (q2e_pkg::SQRT_STEPS - 1 - STEP));

  q2e_pkg::word_t trial;
  q2e_pkg::word_t n_next, res_next;

  always_comb begin
    trial = res_in + BIT;
    if (n_in >= trial) begin
      n_next   = n_in - trial;
      res_next = (res_in >>> 1) + BIT;
    end else begin
      n_next   = n_in;
      res_next = res_in >>> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_out    <= n_next;
      res_out  <= res_next;
      side_out <= side_in;
    end
  end

endmodule

/* rtl/core/q2e_cordic_cell.sv */
`timescale 1ns / 1ps
module q2e_cordic_cell #(
  parameter int STAGE = 0
) (
  input  logic           clk,
  input  logic           en,
  input  q2e_pkg::lane_t lane_in,
  output q2e_pkg::lane_t lane_out
);

  q2e_pkg::word_t dx, dy;
  q2e_pkg::lane_t lane_next;

  always_comb begin
    dx = lane_in.y >>> STAGE;
    dy = lane_in.x >>> STAGE;
    lane_next.zero = lane_in.zero;
    if (lane_in.y >= 0) begin
      lane_next.x = lane_in.x + dx;
      lane_next.y = lane_in.y - dy;
      lane_next.z = lane_in.z + q2e_pkg::atan_unit(STAGE);
    end else begin
      lane_next.x = lane_in.x - dx;
      lane_next.y = lane_in.y + dy;
      lane_next.z = lane_in.z - q2e_pkg::atan_unit(STAGE);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lane_out <= lane_next;
    end
  end

endmodule

/* rtl/core/quaternion_to_euler_angles.sv */
`timescale 1ns / 1ps
// Path: front rows, root cells, fold row, CORDIC rows, then the output register.
// Throughput: one beat per cycle; every stage is a register row, so a beat enters
// each cycle unless the output skid register is occupied.
// Reset: rst (synchronous, active high) empties the pipeline, output and skid
// registers; payload registers are not reset.
module quaternion_to_euler_angles #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  q2e_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output q2e_pkg::out_t  out_data
);

  // Stage map: products, sums, square (front), then the root cells, one
  // quadrant-fold row, then the CORDIC rows.
  localparam int ST_SQRT0 = 3;
  localparam int ST_PRE   = ST_SQRT0 + q2e_pkg::SQRT_STEPS;
  localparam int DEPTH    = ST_PRE + 1 + CORDIC_STAGES;
  localparam int LANES    = 3;   // roll, pitch, yaw
  localparam int L_ROLL   = 0;
  localparam int L_PITCH  = 1;
  localparam int L_YAW    = 2;
  localparam q2e_pkg::word_t RND = q2e_pkg::word_t'(64'sd1) <<< (q2e_pkg::ANGLE_SH - 1);
  localparam q2e_pkg::angle_t QUARTER =
    q2e_pkg::angle_t'(1 << (q2e_pkg::ANGLE_WIDTH - 2));

  logic             advance;
  logic [DEPTH-1:0] stage_valid;
  logic             skid_valid;
  q2e_pkg::out_t    skid;
  q2e_pkg::out_t    result;

  // Whole pipeline moves together; only a full skid register stops it,
  // and that register is a flop so in_ready has no combinational path.
  assign advance  = !skid_valid;
  assign in_ready = advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else if (advance) begin
      stage_valid <= {stage_valid[DEPTH-2:0], in_valid};
    end
  end

  // ---- front: products, sums, pitch sine squared
  q2e_pkg::side_t front_side;
  q2e_pkg::word_t root_arg;

  q2e_front u_front (
    .clk      (clk),
    .en       (advance),
    .in_data  (in_data),
    .side     (front_side),
    .root_arg (root_arg)
  );

  // ---- root cells: cos(pitch) = sqrt(1 - s*s), one result bit a row
  q2e_pkg::word_t sq_n   [0:q2e_pkg::SQRT_STEPS];
  q2e_pkg::word_t sq_res [0:q2e_pkg::SQRT_STEPS];
  q2e_pkg::side_t sq_side[0:q2e_pkg::SQRT_STEPS];

  assign sq_n[0]    = root_arg;
  assign sq_res[0]  = '0;
  assign sq_side[0] = front_side;

  for (genvar k = 0; k < q2e_pkg::SQRT_STEPS; k++) begin : g_sqrt
    q2e_sqrt_cell #(.STEP(k)) u_cell (
      .clk      (clk),
      .en       (advance),
      .n_in     (sq_n[k]),
      .res_in   (sq_res[k]),
      .side_in  (sq_side[k]),
      .n_out    (sq_n[k+1]),
      .res_out  (sq_res[k+1]),
      .side_out (sq_side[k+1])
    );
  end

  // ---- quadrant fold row, flags ride beside the lanes
  q2e_pkg::lane_t lane_pre [LANES];
  q2e_pkg::lane_t lane     [LANES][0:CORDIC_STAGES];
  logic [CORDIC_STAGES:0] sat_p;
  logic [CORDIC_STAGES:0] neg_p;
  q2e_pkg::side_t sd;

  assign sd = sq_side[q2e_pkg::SQRT_STEPS];

  always_ff @(posedge clk) begin
    if (advance) begin
      lane_pre[L_ROLL]  <= q2e_pkg::cordic_pre(sd.sr, sd.cr);
      lane_pre[L_PITCH] <= q2e_pkg::cordic_pre(sd.sp, sq_res[q2e_pkg::SQRT_STEPS]);
      lane_pre[L_YAW]   <= q2e_pkg::cordic_pre(sd.sy, sd.cy);
      sat_p             <= {sat_p[CORDIC_STAGES-1:0], sd.sat};
      neg_p             <= {neg_p[CORDIC_STAGES-1:0], sd.sat_neg};
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_pre
    assign lane[l][0] = lane_pre[l];
  end

  // ---- CORDIC rows, three lanes in step
  for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_cordic
    for (genvar l = 0; l < LANES; l++) begin : g_lane
      q2e_cordic_cell #(.STAGE(s)) u_cell (
        .clk      (clk),
        .en       (advance),
        .lane_in  (lane[l][s]),
        .lane_out (lane[l][s+1])
      );
    end
  end

  // ---- round to binary angles; zero vector gives zero
  q2e_pkg::word_t rounded [LANES];
  q2e_pkg::angle_t angle  [LANES];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      rounded[l] = (lane[l][CORDIC_STAGES].z + RND) >>> q2e_pkg::ANGLE_SH;
      angle[l]   = lane[l][CORDIC_STAGES].zero ? '0
                 : rounded[l][q2e_pkg::ANGLE_WIDTH-1:0];
    end
    result.roll_angle      = angle[L_ROLL];
    result.yaw_angle       = angle[L_YAW];
    result.pitch_saturated = sat_p[CORDIC_STAGES];
    if (sat_p[CORDIC_STAGES]) begin
      result.pitch_angle = neg_p[CORDIC_STAGES] ? -QUARTER : QUARTER;
    end else begin
      result.pitch_angle = angle[L_PITCH];
    end
  end

  // ---- output register plus skid: a beat still in flight when the sink
  // stalls lands in the skid, after which the pipeline holds.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (advance) begin
      if (!out_valid || out_ready) begin
        out_valid <= stage_valid[DEPTH-1];
      end else if (stage_valid[DEPTH-1]) begin
        skid_valid <= 1'b1;
      end
    end else if (!out_valid || out_ready) begin
      out_valid  <= 1'b1;
      skid_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (!out_valid || out_ready) begin
        out_data <= result;
      end else begin
        skid <= result;
      end
    end else if (!out_valid || out_ready) begin
      out_data <= skid;
    end
  end

  // ---- checks
  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid full while output empty");

  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    (!skid_valid && out_valid && !out_ready && stage_valid[DEPTH-1]) |=> skid_valid)
    else $error("stalled beat not captured in skid");

  a_idle_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

  a_sat_clamp: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.pitch_saturated) |->
      (out_data.pitch_angle == QUARTER || out_data.pitch_angle == -QUARTER))
    else $error("saturated pitch not clamped");

endmodule

/* dv/quaternion_to_euler_angles_tb.sv */
`timescale 1ns / 1ps
module quaternion_to_euler_angles_tb;

  localparam int STAGES      = 16;
  localparam int LATENCY     = STAGES + 36;
  localparam int STALL_LIMIT = 4000;
  localparam int N_RANDOM    = 1700;
  localparam logic signed [15:0] ONE = 16'sd16384;

  // stimulus phases: how often each side idles, in cycles out of a hundred
  typedef enum int {PH_FLAT, PH_SRC_GAPS, PH_SNK_STALL, PH_BOTH} phase_e;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  q2e_pkg::in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  q2e_pkg::out_t out_data;

  always #6 clk = ~clk;

  quaternion_to_euler_angles #(.CORDIC_STAGES(STAGES)) u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // angle predictor -------------------------------------------------------
  typedef logic signed [63:0] s64_t;

  localparam s64_t UNIT = 64'sd1 <<< 30;
  localparam logic [31:0] ARCTAN [0:31] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
  };

  // Q1.14 x Q1.14 is Q2.28; lift to Q.30 exactly
  function automatic s64_t q30_mul(input q2e_pkg::comp_t a, input q2e_pkg::comp_t b);
    s64_t p;
    p = s64_t'(a) * s64_t'(b);
    return p <<< 2;
  endfunction

  function automatic logic [63:0] root_floor(input logic [63:0] n);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // vectoring rotation, result in units where 2^31 is pi
  function automatic s64_t vector_angle(input s64_t sy, input s64_t sx);
    s64_t ang, t, dx, dy;
    if (sx == 0 && sy == 0) return 0;
    ang = 0;
    if (sx < 0) begin
      t = sx;
      if (sy >= 0) begin
        sx = sy; sy = -t; ang = UNIT;
      end else begin
        sx = -sy; sy = t; ang = -UNIT;
      end
    end
    for (int i = 0; i < STAGES; i++) begin
      dx = sy >>> i;
      dy = sx >>> i;
      if (sy >= 0) begin
        sx += dx; sy -= dy; ang += s64_t'({32'd0, ARCTAN[i]});
      end else begin
        sx -= dx; sy += dy; ang -= s64_t'({32'd0, ARCTAN[i]});
      end
    end
    return ang;
  endfunction

  function automatic q2e_pkg::angle_t bin_angle(input s64_t a);
    s64_t r;
    r = (a + (64'sd1 <<< 15)) >>> 16;
    return q2e_pkg::angle_t'(r[15:0]);
  endfunction

  function automatic q2e_pkg::out_t euler_zyx(input q2e_pkg::in_t q);
    q2e_pkg::out_t o;
    s64_t sr, cr, sy, cy, sp, cp;
    logic [63:0] sq;
    sr = 2 * (q30_mul(q.quat_w, q.quat_x) + q30_mul(q.quat_y, q.quat_z));
    cr = UNIT - 2 * (q30_mul(q.quat_x, q.quat_x) + q30_mul(q.quat_y, q.quat_y));
    sy = 2 * (q30_mul(q.quat_w, q.quat_z) + q30_mul(q.quat_x, q.quat_y));
    cy = UNIT - 2 * (q30_mul(q.quat_y, q.quat_y) + q30_mul(q.quat_z, q.quat_z));
    sp = 2 * (q30_mul(q.quat_w, q.quat_y) - q30_mul(q.quat_z, q.quat_x));
    o.pitch_saturated = 1'b0;
    if (sp >= UNIT) begin
      o.pitch_angle = 16'sd16384;
      o.pitch_saturated = 1'b1;
    end else if (sp <= -UNIT) begin
      o.pitch_angle = -16'sd16384;
      o.pitch_saturated = 1'b1;
    end else begin
      sq = sp * sp;
      cp = s64_t'(root_floor((64'd1 << 60) - sq));
      o.pitch_angle = bin_angle(vector_angle(sp, cp));
    end
    o.roll_angle = bin_angle(vector_angle(sr, cr));
    o.yaw_angle  = bin_angle(vector_angle(sy, cy));
    return o;
  endfunction

  // scoreboard ------------------------------------------------------------
  q2e_pkg::out_t pending_angles[$];
  int   n_errors   = 0;
  int   n_beats_in = 0;
  int   n_results  = 0;
  int   n_clamped  = 0;
  int   idle_count = 0;
  int   src_gap    = 0;
  int   snk_stall  = 0;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] %s: got %0d, expected %0d", $realtime, what, got, want);
    n_errors++;
  endtask

  // beats counted at the rising edge; expectations queued at acceptance
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        pending_angles.push_back(euler_zyx(in_data));
        n_beats_in++;
      end
      if (out_valid && out_ready) begin
        n_results++;
        if (pending_angles.size() == 0) begin
          report_mismatch("result with nothing pending", 1, 0);
        end else begin
          automatic q2e_pkg::out_t e = pending_angles.pop_front();
          if (out_data.roll_angle != e.roll_angle)
            report_mismatch("roll", out_data.roll_angle, e.roll_angle);
          if (out_data.pitch_angle != e.pitch_angle)
            report_mismatch("pitch", out_data.pitch_angle, e.pitch_angle);
          if (out_data.yaw_angle != e.yaw_angle)
            report_mismatch("yaw", out_data.yaw_angle, e.yaw_angle);
          if (out_data.pitch_saturated != e.pitch_saturated)
            report_mismatch("pitch clamp", out_data.pitch_saturated, e.pitch_saturated);
          if (e.pitch_saturated) n_clamped++;
        end
      end
      // watchdog: cycles with no beat on either side
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_count <= 0;
      else idle_count <= idle_count + 1;
      if (idle_count >= STALL_LIMIT) begin
        $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // receiver: out_ready redrawn at the falling edge by the current stall rate
  always @(negedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= snk_stall);
  end

  // directed rows: expected value filled in only where obvious
  typedef struct {
    q2e_pkg::in_t  q;
    logic          known;
    q2e_pkg::out_t want;
  } row_t;

  row_t rows[$];

  function automatic q2e_pkg::in_t quat(input int w, input int x, input int y, input int z);
    q2e_pkg::in_t q;
    q.quat_w = q2e_pkg::comp_t'(w);
    q.quat_x = q2e_pkg::comp_t'(x);
    q.quat_y = q2e_pkg::comp_t'(y);
    q.quat_z = q2e_pkg::comp_t'(z);
    return q;
  endfunction

  function automatic q2e_pkg::out_t angles(input int r, input int p, input int y,
                                           input logic s);
    q2e_pkg::out_t o;
    o.roll_angle = q2e_pkg::angle_t'(r);
    o.pitch_angle = q2e_pkg::angle_t'(p);
    o.yaw_angle = q2e_pkg::angle_t'(y);
    o.pitch_saturated = s;
    return o;
  endfunction

  task automatic add_row(input q2e_pkg::in_t q, input logic k, input q2e_pkg::out_t o);
    row_t r;
    r.q = q;
    r.known = k;
    r.want = o;
    rows.push_back(r);
  endtask

  // one input beat; valid held until accepted, gap drawn per beat,
  // valid dropped only while idling so beats can follow back to back
  task automatic send_beat(input q2e_pkg::in_t q);
    while ($urandom_range(99) < src_gap) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= q;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // unit quaternion with random direction, rough normalisation
  function automatic q2e_pkg::in_t rand_unit();
    int c[4];
    longint n2;
    int s;
    n2 = 0;
    for (int i = 0; i < 4; i++) begin
      c[i] = $urandom_range(32768) - 16384;
      n2 += longint'(c[i]) * c[i];
    end
    if (n2 == 0) return quat(ONE, 0, 0, 0);
    s = int'($sqrt(real'(n2)));
    for (int i = 0; i < 4; i++) c[i] = int'(longint'(c[i]) * 16384 / s);
    return quat(c[0], c[1], c[2], c[3]);
  endfunction

  q2e_pkg::in_t  q;
  q2e_pkg::out_t pred;
  int   wait_cycles;

  initial begin
    // identity, 180 deg about x and z (pi wraps), zero quaternion, gimbal lock both signs;
    // at gimbal lock 1-2y^2 dips just below zero, so roll and yaw land on pi
    add_row(quat(16384, 0, 0, 0), 1'b1, angles(0, 0, 0, 1'b0));
    add_row(quat(0, 16384, 0, 0), 1'b1, angles(-32768, 0, 0, 1'b0));
    add_row(quat(0, 0, 0, 16384), 1'b1, angles(0, 0, -32768, 1'b0));
    add_row(quat(11585, 0, 11586, 0), 1'b1, angles(-32768, 16384, -32768, 1'b1));
    add_row(quat(11585, 0, -11586, 0), 1'b1, angles(-32768, -16384, -32768, 1'b1));
    add_row(quat(0, 0, 0, 0), 1'b1, angles(0, 0, 0, 1'b0));
    add_row(quat(16384, 16384, 16384, 16384), 1'b0, '0);
    add_row(quat(-16384, -16384, -16384, -16384), 1'b0, '0);
    add_row(quat(-16384, 16384, -16384, 16384), 1'b0, '0);
    add_row(quat(32767, -32768, 32767, -32768), 1'b0, '0);
    add_row(quat(-32768, 32767, -32768, 32767), 1'b0, '0);
    add_row(quat(-1, -1, -1, -1), 1'b0, '0);
    add_row(quat(11585, 11585, 0, 0), 1'b0, '0);
    add_row(quat(11585, 0, 0, -11585), 1'b0, '0);
    add_row(quat(8192, 8192, 8192, 8192), 1'b0, '0);
    add_row(quat(0, 11585, 0, 11585), 1'b0, '0);
    add_row(quat(16383, 1, 1, 1), 1'b0, '0);
    add_row(quat(0, 0, 16384, 0), 1'b0, '0);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed rows checked here for the obvious ones; all go through the predictor too
    foreach (rows[i]) begin
      if (rows[i].known) begin
        pred = euler_zyx(rows[i].q);
        if (pred != rows[i].want)
          report_mismatch("directed row predictor", i, int'(pred.roll_angle));
      end
      send_beat(rows[i].q);
    end

    for (int ph = PH_FLAT; ph <= PH_BOTH; ph++) begin
      case (phase_e'(ph))
        PH_FLAT:      begin src_gap = 0;  snk_stall = 0;  end
        PH_SRC_GAPS:  begin src_gap = 75; snk_stall = 0;  end
        PH_SNK_STALL: begin src_gap = 0;  snk_stall = 75; end
        default:      begin src_gap = 6;  snk_stall = 6;  end
      endcase
      for (int n = 0; n < N_RANDOM / 4; n++) begin
        case ($urandom_range(9))
          0, 1, 2, 3, 4, 5: q = rand_unit();
          6: begin
            // near gimbal lock: w ~ +-y, x ~ +-z
            q = rand_unit();
            q.quat_y = $urandom_range(1) ? q.quat_w : -q.quat_w;
            q.quat_z = $urandom_range(1) ? q.quat_x : -q.quat_x;
            q.quat_y = q2e_pkg::comp_t'(q.quat_y + $urandom_range(8) - 4);
          end
          7: q = quat($urandom_range(8) - 4, $urandom_range(8) - 4,
                      $urandom_range(8) - 4, $urandom_range(8) - 4);
          default: q = q2e_pkg::in_t'({$urandom, $urandom});   // raw bit patterns
        endcase
        send_beat(q);
      end
    end
    in_valid <= 1'b0;

    src_gap = 0;
    snk_stall = 0;
    wait_cycles = 0;
    while (pending_angles.size() != 0 && wait_cycles < 20 * LATENCY + STALL_LIMIT) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (LATENCY) @(posedge clk);

    $display("%0d quaternions sent, %0d angle sets returned, %0d with pitch clamped",
             n_beats_in, n_results, n_clamped);
    $display("covered flat flow, source gaps, sink stalls and mixed idling");
    if (n_errors == 0 && pending_angles.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      if (pending_angles.size() != 0)
        $display("%0d expected results never arrived", pending_angles.size());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
